// ----- hdl/qta_pkg.sv -----
// Shared types and constants of the quadtree tile allocator.
`default_nettype none

package qta_pkg;

	localparam int ATLAS_LOG2_DEF = 12;
	localparam int LEVELS_DEF     = 5;

	localparam logic [3:0] MAX_ALLOC_RESET = 4'd11;

	localparam logic [1:0] OP_ALLOC    = 2'd0;
	localparam logic [1:0] OP_FREE     = 2'd1;
	localparam logic [1:0] OP_FREE_ALL = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [12:0] req_size;
		logic [11:0] free_x;
		logic [11:0] free_y;
		logic [11:0] free_size;
	} in_word_t;

	typedef struct packed {
		logic        success;
		logic [11:0] tile_x;
		logic [11:0] tile_y;
		logic [11:0] tile_size;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WT,
		ST_UP,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/quadtree_tile_allocator.sv -----
// Quadtree tile allocator: top level with the node memory and its walk sequencer.
`default_nettype none

// Two-dimensional buddy allocator for square power-of-two tiles in a square atlas of
// edge 2^ATLAS_LOG2, kept as a complete quadtree of LEVELS levels. Each node holds a
// code for the largest free tile below it (0 means nothing free, k means edge
// 2^(k-1)). The root code sits in a register; the codes of the four children of each
// inner node sit together as one row of a synchronous memory, addressed by the
// parent's node index, so one read fetches all four siblings. A row that has not been
// written since reset or the last free-all reads as whole at its level; a valid bit
// per row, cleared at once, gives this, so there is no clearing pass. An allocate
// walks down one level per memory read (issue, then evaluate), keeps the rows it read,
// and then writes the changed rows back bottom-up, one row per level. A free walks the
// same way and also reads the row below the freed tile when that tile has children;
// free-all and rejected requests go straight to the finish state. One item is worked
// on at a time and the input is stalled meanwhile; a finished word moves into the
// output register and waits there while the next item is already taken in. The walk
// only waits when a finished word finds the output register still full and stalled.
module quadtree_tile_allocator
	import qta_pkg::*;
#(
	parameter int ATLAS_LOG2 = ATLAS_LOG2_DEF,
	parameter int LEVELS     = LEVELS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_word_t      out_word
);

	// Code, level, log2 and sum widths.
	localparam int CW      = $clog2(ATLAS_LOG2 + 2);
	localparam int LW      = $clog2(LEVELS) + 1;
	localparam int KW      = 5;
	localparam int SW      = ((ATLAS_LOG2 > 12) ? ATLAS_LOG2 : 12) + 1;
	localparam int MIN_RAW = ATLAS_LOG2 - LEVELS + 1;
	localparam int MIN_K   = (MIN_RAW < 0) ? 0 : MIN_RAW;
	localparam int ROWS_R  = ((1 << (2 * (LEVELS - 1))) - 1) / 3;
	localparam int ROWS    = (ROWS_R < 1) ? 1 : ROWS_R;
	localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DEPTH_P = (LEVELS > 1) ? LEVELS - 1 : 1;
	localparam int PIW     = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1;
	localparam int RW      = 4 * CW;

	function automatic logic [CW-1:0] full_code(input logic [LW-1:0] lv);
		full_code = CW'(ATLAS_LOG2 + 1) - CW'(lv);
	endfunction

	function automatic logic [CW-1:0] row_max(input logic [RW-1:0] r);
		logic [CW-1:0] m;
		m = '0;
		for (int c = 0; c < 4; c++) begin
			if (r[c*CW +: CW] > m) begin
				m = r[c*CW +: CW];
			end
		end
		row_max = m;
	endfunction

	function automatic logic row_whole(input logic [RW-1:0] r, input logic [CW-1:0] f);
		logic w;
		w = 1'b1;
		for (int c = 0; c < 4; c++) begin
			if (r[c*CW +: CW] != f) begin
				w = 1'b0;
			end
		end
		row_whole = w;
	endfunction

	state_t state_q, state_d;

	// Configuration and per-item registers.
	logic [3:0]    max_alloc_q;
	logic [1:0]    op_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] need_q;
	logic [LW-1:0] tl_q;
	logic [LW-1:0] lvl_q;
	logic [AW-1:0] n_q;
	logic [11:0]   fx_q, fy_q, fs_q;
	logic [SW-1:0] px_q, py_q;
	logic [CW-1:0] val_q;
	logic [CW-1:0] root_q;

	// Path kept during the descent: the row read at each level and the child taken.
	logic [RW-1:0] row_q  [DEPTH_P];
	logic [1:0]    pick_q [DEPTH_P];
	logic [AW-1:0] nidx_q [DEPTH_P];

	// Node memory: one row of four sibling codes per inner node.
	logic [RW-1:0] mem [ROWS];
	logic [RW-1:0] rdata_q;
	logic          rdv_q;
	logic [ROWS-1:0] row_valid_q;

	// Result word being built, and the output register that presents it.
	out_word_t res_q;
	out_word_t out_q;
	logic      out_valid_q;

	// Decode of a new request.
	logic [KW-1:0] a_k, f_k, mx_k;
	logic          f_ok;

	always_comb begin
		a_k = '0;
		if (in_word.req_size > 13'd1) begin
			for (int b = 0; b < 13; b++) begin
				if (((in_word.req_size - 13'd1) >> b) != 13'd0) begin
					a_k = KW'(b + 1);
				end
			end
		end
		mx_k = KW'(max_alloc_q);
		if (mx_k > KW'(ATLAS_LOG2 - 1)) begin
			mx_k = KW'(ATLAS_LOG2 - 1);
		end
		if (mx_k < KW'(MIN_K)) begin
			mx_k = KW'(MIN_K);
		end
		if (a_k < KW'(MIN_K)) begin
			a_k = KW'(MIN_K);
		end
		if (a_k > mx_k) begin
			a_k = mx_k;
		end
		f_k = '0;
		for (int b = 0; b < 12; b++) begin
			if (in_word.free_size[b]) begin
				f_k = KW'(b);
			end
		end
		f_ok = (in_word.free_size != 12'd0)
			&& ((in_word.free_size & (in_word.free_size - 12'd1)) == 12'd0)
			&& (f_k >= KW'(MIN_K)) && (f_k <= KW'(ATLAS_LOG2));
	end

	// Evaluation of a returned row.
	logic [RW-1:0] rd_row;
	logic [1:0]    a_pick;
	logic          a_found;
	logic [SW-1:0] h;
	logic          go_y, go_x;
	logic [1:0]    f_pick;
	logic [1:0]    pick;
	logic [AW+2:0] child;
	logic [LW-1:0] lvl_nx;
	logic [PIW-1:0] up_idx;
	logic [RW-1:0] up_row;
	logic [CW-1:0] up_val;
	logic [LW-1:0] lvl_up;

	always_comb begin
		rd_row = rdv_q ? rdata_q : {4{full_code(lvl_q + LW'(1))}};
		a_pick  = 2'd0;
		a_found = 1'b0;
		for (int c = 3; c >= 0; c--) begin
			if (rd_row[c*CW +: CW] >= need_q) begin
				a_pick  = 2'(c);
				a_found = 1'b1;
			end
		end
		h      = SW'(1) << (ATLAS_LOG2 - 1 - int'(lvl_q));
		go_y   = (SW'(fy_q) + SW'(fs_q)) > (py_q + h);
		go_x   = (SW'(fx_q) + SW'(fs_q)) > (px_q + h);
		f_pick = {go_y, go_x};
		pick   = (op_q == OP_ALLOC) ? a_pick : f_pick;
		child  = {3'b000, n_q} * (AW + 3)'(4) + (AW + 3)'(1) + (AW + 3)'(pick);
		lvl_nx = lvl_q + LW'(1);
		lvl_up = lvl_q - LW'(1);
		up_idx = PIW'(lvl_up);
		up_row = row_q[up_idx];
		up_row[pick_q[up_idx]*CW +: CW] = val_q;
		if ((op_q == OP_FREE) && row_whole(up_row, full_code(lvl_q))) begin
			up_val = full_code(lvl_up);
		end else begin
			up_val = row_max(up_row);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FIN;
					if (in_word.opcode == OP_ALLOC) begin
						if (root_q >= CW'(a_k + KW'(1))) begin
							state_d = ST_RD;
						end
					end else if ((in_word.opcode == OP_FREE) && f_ok) begin
						state_d = (LEVELS == 1) ? ST_UP : ST_RD;
					end
				end
			end
			ST_RD: begin
				state_d = ST_WT;
			end
			ST_WT: begin
				if (op_q == OP_ALLOC) begin
					if (!a_found) begin
						state_d = ST_FIN;
					end else if (lvl_nx == tl_q) begin
						state_d = ST_UP;
					end else begin
						state_d = ST_RD;
					end
				end else if (lvl_q == tl_q) begin
					state_d = ST_UP;
				end else if ((lvl_nx < tl_q)
					|| ((lvl_nx == tl_q) && (tl_q != LW'(LEVELS - 1)))) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_UP;
				end
			end
			ST_UP: begin
				if (lvl_q == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_alloc_q <= MAX_ALLOC_RESET;
		end else if (cfg_we) begin
			max_alloc_q <= cfg_wdata;
		end
	end

	// Memory: written during the upward pass, read one row per level on the way down.
	always_ff @(posedge clk) begin
		if (state_q == ST_UP && lvl_q != '0) begin
			mem[nidx_q[up_idx]] <= up_row;
		end
		if (state_q == ST_RD) begin
			rdata_q <= mem[n_q];
		end
	end

	// Control state: row valid bits, root code, output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rdv_q       <= 1'b0;
			root_q      <= full_code('0);
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_RD) begin
				rdv_q <= row_valid_q[n_q];
			end
			if (state_q == ST_IDLE && in_valid && in_word.opcode == OP_FREE_ALL) begin
				row_valid_q <= '0;
				root_q      <= full_code('0);
			end
			if (state_q == ST_UP) begin
				if (lvl_q == '0) begin
					root_q <= val_q;
				end else begin
					row_valid_q[nidx_q[up_idx]] <= 1'b1;
				end
			end
		end
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op_q  <= in_word.opcode;
					fx_q  <= in_word.free_x;
					fy_q  <= in_word.free_y;
					fs_q  <= in_word.free_size;
					px_q  <= '0;
					py_q  <= '0;
					n_q   <= '0;
					lvl_q <= '0;
					val_q <= full_code('0);
					res_q <= '{(in_word.opcode == OP_FREE_ALL), 12'd0, 12'd0, 12'd0};
					if (in_word.opcode == OP_ALLOC) begin
						k_q    <= a_k;
						need_q <= CW'(a_k + KW'(1));
						tl_q   <= LW'(KW'(ATLAS_LOG2) - a_k);
					end else begin
						k_q    <= f_k;
						need_q <= '0;
						tl_q   <= LW'(KW'(ATLAS_LOG2) - f_k);
					end
				end
			end
			ST_RD: begin
			end
			ST_WT: begin
				if (lvl_q < tl_q) begin
					row_q[PIW'(lvl_q)]  <= rd_row;
					pick_q[PIW'(lvl_q)] <= pick;
					nidx_q[PIW'(lvl_q)] <= n_q;
					n_q   <= AW'(child);
					lvl_q <= lvl_nx;
					if (pick[0]) begin
						px_q <= px_q + h;
					end
					if (pick[1]) begin
						py_q <= py_q + h;
					end
					if (op_q == OP_ALLOC) begin
						val_q <= '0;
					end else begin
						val_q <= full_code(lvl_nx);
					end
				end else if (row_whole(rd_row, full_code(lvl_nx))) begin
					val_q <= full_code(lvl_q);
				end else begin
					val_q <= row_max(rd_row);
				end
			end
			ST_UP: begin
				if (lvl_q == '0) begin
					if (op_q == OP_ALLOC) begin
						res_q <= '{1'b1, px_q[11:0], py_q[11:0],
							((k_q < KW'(12)) ? 12'd1 << k_q : 12'd0)};
					end else begin
						res_q.success <= 1'b1;
					end
				end else begin
					val_q <= up_val;
					lvl_q <= lvl_up;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// The root code never claims more than the whole atlas.
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		root_q <= full_code('0))
		else $error("root code above atlas size");

	// Free-all clears every row valid bit in the next cycle.
	a_free_all: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_word.opcode == OP_FREE_ALL) |=> (row_valid_q == '0))
		else $error("free-all left rows valid");

	// A new output word only appears after the finish state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("output word outside finish state");

	// An allocated tile lies on a multiple of its own size.
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.success && out_word.tile_size != 12'd0)
		|-> (((out_word.tile_x | out_word.tile_y) & (out_word.tile_size - 12'd1)) == 12'd0))
		else $error("allocated tile misaligned");

endmodule

`default_nettype wire
